### rtl/core/tsmf_pkg.sv
`default_nettype none

package tsmf_pkg;

  // fixed point format of all ports
  localparam int FRAC_BITS = 16;

  // datapath widths
  localparam int VW = 42;  // vectoring x and y
  localparam int ZW = 34;  // vectoring angle accumulator
  localparam int RW = 33;  // rotation x and y
  localparam int AW = 34;  // rotation angle
  localparam int DW = 53;  // slip ratio dividend

  localparam logic signed [VW-1:0] ONE_Q        = VW'(64'd1 << FRAC_BITS);
  localparam logic [38:0]          ARG_LIM      = 39'd1 << 38;
  localparam logic [30:0]          QUARTER_TURN = 31'd1 << 30;
  localparam logic [30:0]          HALF_PI_Q30  = 31'd1686629713;
  localparam logic signed [RW-1:0] GAIN_INV_Q30 = 33'sd652032874;
  localparam logic signed [23:0]   HUNDRED_Q    = 24'sd6553600;
  localparam logic [31:0]          TENTH_Q      = 32'd6554;
  localparam logic [17:0]          TWO_Q        = 18'd131072;

  // configuration register index
  typedef enum logic [2:0] {
    CFG_RADIUS     = 3'd0,
    CFG_PEAK       = 3'd1,
    CFG_STIFF      = 3'd2,
    CFG_SHAPE_LONG = 3'd3,
    CFG_SHAPE_LAT  = 3'd4,
    CFG_CURV       = 3'd5
  } cfg_idx_e;

  // slip ratio special cases
  typedef enum logic [1:0] {
    SR_CALC,
    SR_POS,
    SR_NEG,
    SR_ZERO
  } sr_case_e;

  // slip angle special cases
  typedef enum logic [1:0] {
    SA_CALC,
    SA_POS,
    SA_NEG,
    SA_ZERO
  } sa_case_e;

  typedef struct packed {
    logic signed [31:0] spin_rate;
    logic signed [31:0] vel_long;
    logic signed [31:0] vel_lat;
    logic               driven;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0] slip_ratio_out;
    logic signed [23:0] slip_angle_out;
    logic signed [31:0] force_long;
    logic signed [31:0] force_lat;
  } out_beat_t;

  // formula coefficients seen by the force unit
  typedef struct packed {
    logic [30:0]        peak_d;
    logic [30:0]        stiff_b;
    logic [30:0]        shape_long;
    logic [30:0]        shape_lat;
    logic signed [31:0] curv_e;
  } mf_cfg_t;

  // side data that rides along with the force pipeline
  typedef struct packed {
    logic signed [23:0] slip_ratio;
    logic signed [23:0] slip_angle;
    logic               driven;
  } tag_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [AW-1:0] a;
  } rot_t;

  // front stage: slip ratio division and slip angle vectoring
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [31:0]   dvs;
    logic [17:0]   quo;
    logic          ovf;
    sr_case_e      rcase;
    logic          wneg;
    vec_t          av;
    sa_case_e      acase;
    logic          aneg;
    logic          driven;
  } fr_t;

  // arctangent of 2^-i as binary angle, quarter turn = 2^30
  function automatic logic [31:0] arc_angle(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // one vectoring micro-rotation
  function automatic vec_t vec_step(input vec_t v, input logic [4:0] s);
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [ZW-1:0] t;
    vec_t r;
    x  = v.x;
    y  = v.y;
    dx = y >>> s;
    dy = x >>> s;
    t  = $signed({2'b00, arc_angle(s)});
    if (!y[VW-1]) begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = v.z + t;
    end else begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = v.z - t;
    end
    return r;
  endfunction

  // one rotation micro-rotation
  function automatic rot_t rot_step(input rot_t v, input logic [4:0] s);
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [RW-1:0] dx;
    logic signed [RW-1:0] dy;
    logic signed [AW-1:0] t;
    rot_t r;
    x  = v.x;
    y  = v.y;
    dx = y >>> s;
    dy = x >>> s;
    t  = $signed({2'b00, arc_angle(s)});
    if (!v.a[AW-1]) begin
      r.x = x - dx;
      r.y = y + dy;
      r.a = v.a - t;
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.a = v.a + t;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tsmf_force.sv
`default_nettype none

module tsmf_force #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [23:0]      s_i [2],
  input  wire tsmf_pkg::tag_t          tag_i,
  input  wire tsmf_pkg::mf_cfg_t       cfg_i,
  output logic                         valid_o,
  output logic signed [31:0]           force_o [2],
  output tsmf_pkg::tag_t               tag_o
);
  import tsmf_pkg::*;

  localparam int N   = CORDIC_STEPS;
  localparam int LAT = 11 + 3 * N;

  // valid and side data delay line
  logic v_q [LAT];
  tag_t tag_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < LAT; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int k = 1; k < LAT; k++) tag_q[k] <= tag_q[k-1];
    end
  end

  assign valid_o = v_q[LAT-1];
  assign tag_o   = tag_q[LAT-1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [30:0] shape;
    assign shape = (l == 0) ? cfg_i.shape_long : cfg_i.shape_lat;

    // stage a: B * |s|
    logic [23:0] s_mag;
    logic [54:0] a_prod_q;
    logic        a_neg_q;
    assign s_mag = s_i[l][23] ? (~s_i[l] + 24'd1) : s_i[l];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_prod_q <= 55'(cfg_i.stiff_b) * 55'(s_mag);
        a_neg_q  <= s_i[l][23];
      end
    end

    // stage b: saturate B*s, start atan(B*s)
    logic [38:0]        b_mag;
    vec_t               c1_q    [N+1];
    logic signed [39:0] c1_bs_q [N+1];
    logic               c1_z_q  [N+1];
    assign b_mag = (a_prod_q[54:16] > ARG_LIM) ? ARG_LIM : a_prod_q[54:16];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c1_q[0].x  <= ONE_Q;
        c1_q[0].y  <= VW'(b_mag);
        c1_q[0].z  <= '0;
        c1_bs_q[0] <= a_neg_q ? -$signed({1'b0, b_mag}) : $signed({1'b0, b_mag});
        c1_z_q[0]  <= (b_mag == '0);
      end
    end

    // vectoring for atan(B*s)
    for (genvar i = 0; i < N; i++) begin : g_c1
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          c1_q[i+1]    <= vec_step(c1_q[i], 5'(i));
          c1_bs_q[i+1] <= c1_bs_q[i];
          c1_z_q[i+1]  <= c1_z_q[i];
        end
      end
    end

    // stage c: clamp angle, scale to radians
    logic [30:0]        c_z;
    logic [61:0]        c_prod_q;
    logic signed [39:0] c_bs_q;
    always_comb begin
      if (c1_z_q[N] || c1_q[N].z[ZW-1]) begin
        c_z = '0;
      end else if (c1_q[N].z > $signed({3'b000, QUARTER_TURN})) begin
        c_z = QUARTER_TURN;
      end else begin
        c_z = c1_q[N].z[30:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_prod_q <= 62'(c_z) * 62'(HALF_PI_Q30);
        c_bs_q   <= c1_bs_q[N];
      end
    end

    // stage d: diff = B*s - atan(B*s), saturated
    logic [17:0]        d_m;
    logic signed [40:0] d_rad;
    logic signed [40:0] d_dd;
    logic [40:0]        d_abs;
    logic [38:0]        d_mag_q;
    logic               d_neg_q;
    logic signed [39:0] d_bs_q;
    logic [61:0]        d_sum;
    assign d_sum = c_prod_q + (62'd1 << 43);
    assign d_m   = d_sum[61:44];
    assign d_rad = c_bs_q[39] ? -$signed({23'b0, d_m}) : $signed({23'b0, d_m});
    assign d_dd  = 41'(c_bs_q) - d_rad;
    assign d_abs = d_dd[40] ? (~d_dd + 41'd1) : d_dd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_mag_q <= (d_abs > 41'(ARG_LIM)) ? ARG_LIM : d_abs[38:0];
        d_neg_q <= d_dd[40];
        d_bs_q  <= c_bs_q;
      end
    end

    // stage e: |E| * |diff| as two partial products
    logic [31:0]        e_em;
    logic [51:0]        e_pl_q;
    logic [50:0]        e_ph_q;
    logic               e_neg_q;
    logic signed [39:0] e_bs_q;
    assign e_em = cfg_i.curv_e[31] ? (~cfg_i.curv_e + 32'd1) : cfg_i.curv_e;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_pl_q  <= 52'(e_em) * 52'(d_mag_q[19:0]);
        e_ph_q  <= 51'(e_em) * 51'(d_mag_q[38:20]);
        e_neg_q <= cfg_i.curv_e[31] ^ d_neg_q;
        e_bs_q  <= d_bs_q;
      end
    end

    // stage f: combine partials, saturate E*diff
    logic [70:0]        f_prod;
    logic [38:0]        f_ep_q;
    logic               f_neg_q;
    logic signed [39:0] f_bs_q;
    assign f_prod = {e_ph_q, 20'b0} + 71'(e_pl_q);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_ep_q  <= (f_prod[70:16] > 55'(ARG_LIM)) ? ARG_LIM : f_prod[54:16];
        f_neg_q <= e_neg_q;
        f_bs_q  <= e_bs_q;
      end
    end

    // stage g: arg = B*s - E*diff, saturated, start atan(arg)
    logic signed [40:0] g_sum;
    logic [40:0]        g_abs;
    logic [38:0]        g_mag;
    vec_t               c2_q   [N+1];
    logic               c2_n_q [N+1];
    logic               c2_z_q [N+1];
    assign g_sum = f_neg_q ? (41'(f_bs_q) + $signed({2'b00, f_ep_q}))
                           : (41'(f_bs_q) - $signed({2'b00, f_ep_q}));
    assign g_abs = g_sum[40] ? (~g_sum + 41'd1) : g_sum;
    assign g_mag = (g_abs > 41'(ARG_LIM)) ? ARG_LIM : g_abs[38:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c2_q[0].x <= ONE_Q;
        c2_q[0].y <= VW'(g_mag);
        c2_q[0].z <= '0;
        c2_n_q[0] <= g_sum[40];
        c2_z_q[0] <= (g_mag == '0);
      end
    end

    // vectoring for atan(arg)
    for (genvar i = 0; i < N; i++) begin : g_c2
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          c2_q[i+1]   <= vec_step(c2_q[i], 5'(i));
          c2_n_q[i+1] <= c2_n_q[i];
          c2_z_q[i+1] <= c2_z_q[i];
        end
      end
    end

    // stage h: C * |phi|
    logic [30:0] h_z;
    logic [61:0] h_prod_q;
    logic        h_neg_q;
    always_comb begin
      if (c2_z_q[N] || c2_q[N].z[ZW-1]) begin
        h_z = '0;
      end else if (c2_q[N].z > $signed({3'b000, QUARTER_TURN})) begin
        h_z = QUARTER_TURN;
      end else begin
        h_z = c2_q[N].z[30:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        h_prod_q <= 62'(shape) * 62'(h_z);
        h_neg_q  <= c2_n_q[N];
      end
    end

    // stage i: wrap to a binary angle, fold into the right half plane
    logic [31:0]          i_th;
    logic [31:0]          i_ang;
    logic signed [AW-1:0] i_a;
    logic signed [AW-1:0] i_fold;
    rot_t                 c3_q [N+1];
    assign i_th  = h_prod_q[47:16];
    assign i_ang = h_neg_q ? (~i_th + 32'd1) : i_th;
    assign i_a   = AW'($signed(i_ang));

    always_comb begin
      if (i_a > $signed({3'b000, QUARTER_TURN})) begin
        i_fold = (AW'(2) * $signed({3'b000, QUARTER_TURN})) - i_a;
      end else if (i_a < -$signed({3'b000, QUARTER_TURN})) begin
        i_fold = -(AW'(2) * $signed({3'b000, QUARTER_TURN})) - i_a;
      end else begin
        i_fold = i_a;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c3_q[0].x <= GAIN_INV_Q30;
        c3_q[0].y <= '0;
        c3_q[0].a <= i_fold;
      end
    end

    // rotation for sin
    for (genvar i = 0; i < N; i++) begin : g_c3
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          c3_q[i+1] <= rot_step(c3_q[i], 5'(i));
        end
      end
    end

    // stage j: clamp sin, D * |sin|
    logic signed [RW-1:0] j_y;
    logic [RW-1:0]        j_abs;
    logic [30:0]          j_mag;
    logic [61:0]          j_prod_q;
    logic                 j_neg_q;
    assign j_y   = c3_q[N].y;
    assign j_abs = j_y[RW-1] ? (~j_y + RW'(1)) : j_y;
    assign j_mag = (j_abs > RW'(QUARTER_TURN)) ? QUARTER_TURN : j_abs[30:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        j_prod_q <= 62'(cfg_i.peak_d) * 62'(j_mag);
        j_neg_q  <= j_y[RW-1];
      end
    end

    // stage k: round and restore the sign
    logic [61:0]        k_sum;
    logic [31:0]        k_m;
    logic signed [31:0] k_f_q;
    assign k_sum = j_prod_q + (62'd1 << 29);
    assign k_m   = k_sum[61:30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        k_f_q <= j_neg_q ? $signed(~k_m + 32'd1) : $signed(k_m);
      end
    end

    assign force_o[l] = k_f_q;
  end

endmodule

`default_nettype wire

### rtl/core/tire_slip_magic_formula_force.sv
`default_nettype none

// Per-wheel tire force unit. One wheel beat (spin rate, longitudinal and
// lateral velocity, driven flag) enters per clock and produces one result
// beat with slip ratio, slip angle and the magic formula longitudinal and
// lateral forces; slips are signed Q8.16, forces signed Q16.16. The
// 19-step slip ratio divider runs beside the slip angle CORDIC and is
// followed by three chained CORDIC pipelines (two arctangents and one
// sine) per force. Throughput is one beat per cycle; while a result
// beat waits with out_ready_i low the whole pipeline holds and in_ready_o
// drops. A non-driven wheel reports zero longitudinal force. The user must
// write coefficient registers through the cfg port only while no beat is
// in flight; the block itself does not enforce this.
module tire_slip_magic_formula_force #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tsmf_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tsmf_pkg::out_beat_t      out_data_o
);
  import tsmf_pkg::*;

  localparam int DIV_STEPS = 19;
  localparam int FL = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;

  // coefficient registers
  logic [20:0] radius_q;
  mf_cfg_t     cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q         <= 21'd22938;
      cfg_q.peak_d     <= 31'd240844800;
      cfg_q.stiff_b    <= 31'd655;
      cfg_q.shape_long <= 31'd108134;
      cfg_q.shape_lat  <= 31'd85197;
      cfg_q.curv_e     <= 32'sd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RADIUS:     radius_q         <= cfg_data_i[20:0];
        CFG_PEAK:       cfg_q.peak_d     <= cfg_data_i[30:0];
        CFG_STIFF:      cfg_q.stiff_b    <= cfg_data_i[30:0];
        CFG_SHAPE_LONG: cfg_q.shape_long <= cfg_data_i[30:0];
        CFG_SHAPE_LAT:  cfg_q.shape_lat  <= cfg_data_i[30:0];
        CFG_CURV:       cfg_q.curv_e     <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output holds a beat that is not taken
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // entry stage: magnitudes, special cases, |spin| * radius
  logic [31:0]        uw;
  logic [31:0]        vxm;
  logic [31:0]        vym;
  logic               vx_pos;
  logic               vy_pos;
  fr_t                t1;
  logic signed [31:0] w;
  logic signed [31:0] vx;
  logic signed [31:0] vy;

  assign w      = in_data_i.spin_rate;
  assign vx     = in_data_i.vel_long;
  assign vy     = in_data_i.vel_lat;
  assign uw     = w[31] ? (~w + 32'd1) : w;
  assign vxm    = vx[31] ? (~vx + 32'd1) : vx;
  assign vym    = vy[31] ? (~vy + 32'd1) : vy;
  assign vx_pos = !vx[31] && (vx != '0);
  assign vy_pos = !vy[31] && (vy != '0);

  always_comb begin
    t1.rem    = DW'(uw) * DW'(radius_q);
    t1.dvs    = (vxm < TENTH_Q) ? TENTH_Q : vxm;
    t1.quo    = '0;
    t1.ovf    = 1'b0;
    t1.wneg   = w[31];
    t1.driven = in_data_i.driven;
    if (!w[31] && vx[31]) begin
      t1.rcase = SR_POS;
    end else if ((w[31] || (w == '0)) && vx_pos) begin
      t1.rcase = SR_NEG;
    end else if (uw <= TENTH_Q) begin
      t1.rcase = SR_ZERO;
    end else begin
      t1.rcase = SR_CALC;
    end
    t1.av.x = VW'(vxm);
    t1.av.y = VW'(vym);
    t1.av.z = '0;
    t1.aneg = vy_pos;
    if (vx == '0) begin
      t1.acase = (vy == '0) ? SA_ZERO : (vy_pos ? SA_NEG : SA_POS);
    end else if (vy == '0) begin
      t1.acase = SA_ZERO;
    end else begin
      t1.acase = SA_CALC;
    end
  end

  // front pipeline: restoring divider and slip angle vectoring in lockstep
  fr_t  fr_q  [FL+1];
  logic fv_q  [FL+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= FL; k++) fv_q[k] <= 1'b0;
    end else if (adv) begin
      fv_q[0] <= in_valid_i;
      for (int k = 1; k <= FL; k++) fv_q[k] <= fv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) fr_q[0] <= t1;
  end

  for (genvar k = 0; k < FL; k++) begin : g_front
    fr_t dn;
    fr_t nx;
    if (k == 0) begin : g_ovf
      // quotient of 2^18 or more ends up clamped
      always_comb begin
        dn     = fr_q[k];
        dn.ovf = fr_q[k].rem >= {3'b000, fr_q[k].dvs, 18'b0};
      end
    end else if (k < DIV_STEPS) begin : g_div
      logic [DW-1:0] sh;
      assign sh = DW'(fr_q[k].dvs) << (DIV_STEPS - 1 - k);
      always_comb begin
        dn = fr_q[k];
        if (!fr_q[k].ovf && (fr_q[k].rem >= sh)) begin
          dn.rem                     = fr_q[k].rem - sh;
          dn.quo[DIV_STEPS - 1 - k] = 1'b1;
        end
      end
    end else begin : g_pass
      assign dn = fr_q[k];
    end

    always_comb begin
      nx = dn;
      if (k < CORDIC_STEPS) nx.av = vec_step(fr_q[k].av, 5'(k));
    end

    always_ff @(posedge clk_i) begin
      if (adv) fr_q[k+1] <= nx;
    end
  end

  // finish slip ratio and slip angle
  fr_t                fe;
  logic [17:0]        qc;
  logic signed [25:0] rq;
  logic signed [25:0] rv;
  logic signed [23:0] sr;
  logic [30:0]        zc;
  logic [37:0]        am;
  logic [23:0]        amc;
  logic signed [23:0] sa;

  assign fe = fr_q[FL];

  always_comb begin
    if (fe.ovf || (fe.quo > TWO_Q)) begin
      qc = TWO_Q;
    end else begin
      qc = fe.quo;
    end
    rq = $signed({8'b0, qc}) - 26'sd65536;
    rv = rq * 26'sd100;
    unique case (fe.rcase)
      SR_POS:  sr = HUNDRED_Q;
      SR_NEG:  sr = -HUNDRED_Q;
      SR_ZERO: sr = '0;
      default: sr = fe.wneg ? -rv[23:0] : rv[23:0];
    endcase
  end

  always_comb begin
    if (fe.av.z[ZW-1]) begin
      zc = '0;
    end else if (fe.av.z > $signed({3'b000, QUARTER_TURN})) begin
      zc = QUARTER_TURN;
    end else begin
      zc = fe.av.z[30:0];
    end
    am  = (38'(zc) * 38'd100 + 38'd8192) >> 14;
    amc = (am > 38'(HUNDRED_Q)) ? HUNDRED_Q : am[23:0];
    unique case (fe.acase)
      SA_POS:  sa = HUNDRED_Q;
      SA_NEG:  sa = -HUNDRED_Q;
      SA_ZERO: sa = '0;
      default: sa = fe.aneg ? -$signed(amc) : $signed(amc);
    endcase
  end

  logic               sl_v_q;
  logic signed [23:0] sl_s_q [2];
  tag_t               sl_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_v_q <= 1'b0;
    end else if (adv) begin
      sl_v_q <= fv_q[FL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sl_s_q[0]           <= sr;
      sl_s_q[1]           <= sa;
      sl_tag_q.slip_ratio <= sr;
      sl_tag_q.slip_angle <= sa;
      sl_tag_q.driven     <= fe.driven;
    end
  end

  // magic formula, longitudinal in lane 0, lateral in lane 1
  logic               mf_v;
  logic signed [31:0] mf_f [2];
  tag_t               mf_tag;

  tsmf_force #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sl_v_q),
    .s_i     (sl_s_q),
    .tag_i   (sl_tag_q),
    .cfg_i   (cfg_q),
    .valid_o (mf_v),
    .force_o (mf_f),
    .tag_o   (mf_tag)
  );

  // output register
  logic      out_v_q;
  out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= mf_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.slip_ratio_out <= mf_tag.slip_ratio;
      out_q.slip_angle_out <= mf_tag.slip_angle;
      out_q.force_long     <= mf_tag.driven ? mf_f[0] : '0;
      out_q.force_lat      <= mf_f[1];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/tsmf_chk.sv
`default_nettype none

module tsmf_chk (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire tsmf_pkg::out_beat_t out_data_o
);
  import tsmf_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a stalled output freezes the input side
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipeline stalled");

  // input only backs up behind a waiting result
  a_ready_why: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input not ready with empty output");

  // slip fields stay within plus or minus 100
  a_slip_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.slip_ratio_out <= HUNDRED_Q)
                 && (out_data_o.slip_ratio_out >= -HUNDRED_Q)
                 && (out_data_o.slip_angle_out <= HUNDRED_Q)
                 && (out_data_o.slip_angle_out >= -HUNDRED_Q))
    else $error("slip field out of range");

endmodule

bind tire_slip_magic_formula_force tsmf_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
